// File: design/ptsb_pkg.sv
// Package for the periodic timer slot bank.
// Field widths, operation codes and the entry, mask and result types.
// No dependencies.
package ptsb_pkg;

  localparam int OPC_W  = 3;
  localparam int SLOT_W = 3;
  localparam int TICK_W = 32;
  localparam int FCNT_W = 4;

  typedef logic [OPC_W-1:0]  opcode_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [FCNT_W-1:0] fcnt_t;

  // operation codes
  localparam opcode_t OP_SCAN    = 3'd0;
  localparam opcode_t OP_CREATE  = 3'd1;
  localparam opcode_t OP_SET_PER = 3'd2;
  localparam opcode_t OP_START   = 3'd3;
  localparam opcode_t OP_STOP    = 3'd4;
  localparam opcode_t OP_RELEASE = 3'd5;

  // at most this many fire beats per scan
  localparam fcnt_t MAX_FIRES = 4'd8;
  localparam fcnt_t LAST_FIRE = 4'd7;

  // one memory entry per slot
  typedef struct packed {
    tick_t remaining;
    tick_t period;
    tick_t start;
  } entry_t;

  // per-field write enables
  typedef struct packed {
    logic remaining;
    logic period;
    logic start;
  } wmask_t;

  // expiry check of one slot
  typedef struct packed {
    logic  fire;
    tick_t remaining;
    logic  enabled;
  } expiry_t;

  // one fire beat
  typedef struct packed {
    slot_t fired_slot;
    tick_t remaining_count;
    logic  still_enabled;
    logic  last_fire;
  } result_t;

endpackage

// File: design/ptsb_if.sv
// Valid/ready channel interfaces of the periodic timer slot bank.
// ptsb_in_if carries operations, ptsb_out_if carries fire beats.
// Depends on ptsb_pkg.
interface ptsb_in_if import ptsb_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  slot_t   slot;
  tick_t   time_now;
  tick_t   period_value;
  tick_t   cycle_count;

  modport source (output valid, opcode, slot, time_now, period_value, cycle_count,
                  input ready);
  modport sink   (input valid, opcode, slot, time_now, period_value, cycle_count,
                  output ready);
endinterface

interface ptsb_out_if import ptsb_pkg::*; ();
  logic  valid;
  logic  ready;
  slot_t fired_slot;
  tick_t remaining_count;
  logic  still_enabled;
  logic  last_fire;

  modport source (output valid, fired_slot, remaining_count, still_enabled, last_fire,
                  input ready);
  modport sink   (input valid, fired_slot, remaining_count, still_enabled, last_fire,
                   output ready);
endinterface

// File: design/ptsb_mem.sv
// Slot memory: remaining count, period and start time for every slot.
// One masked write port, one read port with registered data.
// Depends on ptsb_pkg.
module ptsb_mem import ptsb_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  wmask_t        wr_mask,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // masked write, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_mask.remaining) mem[wr_addr].remaining <= wr_data.remaining;
      if (wr_mask.period)    mem[wr_addr].period    <= wr_data.period;
      if (wr_mask.start)     mem[wr_addr].start     <= wr_data.start;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/ptsb_expiry.sv
// Expiry check and count update for the slot being scanned.
// Pure logic on the entry read from the slot memory.
// Depends on ptsb_pkg.
module ptsb_expiry import ptsb_pkg::*; (
  input  entry_t  entry,
  input  tick_t   now,
  input  logic    live,
  input  logic    looping,
  output expiry_t result
);

  tick_t elapsed;
  tick_t rem_dec;

  // elapsed ticks wrap modulo 2^32
  assign elapsed = now - entry.start;

  // a nonzero count goes down by one
  assign rem_dec = (entry.remaining != '0) ? entry.remaining - 1'b1 : entry.remaining;

  always_comb begin
    result.fire      = live && (elapsed > entry.period);
    result.remaining = rem_dec;
    result.enabled   = (rem_dec != '0) || looping;
  end

endmodule

// File: design/periodic_timer_slot_bank.sv
// Periodic timer slot bank: top level.
// Depends on ptsb_pkg, ptsb_if, ptsb_mem and ptsb_expiry.
//
// in_ch takes one operation per beat: scan, create, set period, start, stop
// or release, with the slot, the current tick and the period or cycle count.
// Slot operations complete in the accept cycle, so they can follow each other
// every cycle. A scan reads one slot per cycle from the slot memory, unless
// fire beats wait on a stalled receiver, and holds in_ch off until it has
// passed its final beat to the output register; then in_ch is ready again.
// out_ch carries one beat per expiring slot in ascending slot order, at most
// eight per scan; last_fire marks the final beat of a scan. A scan with no
// expiring slot gives no beat. Each beat is held back until it is known
// whether another follows in the same scan.
// When out_ch stalls, the output register and one held beat keep results; a
// third fire stops the scan until the output register drains. Operations are
// still accepted while the final beat waits to be taken.
// Reset clears the valid, enabled and looping bits of all slots and empties
// the output; the slot memory needs no clearing.
module periodic_timer_slot_bank import ptsb_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ptsb_in_if.sink     in_ch,
  ptsb_out_if.source  out_ch
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [IDX_W-1:0]     eval_idx_r, eval_idx_nxt;
  tick_t                now_r, now_nxt;
  fcnt_t                fire_cnt_r, fire_cnt_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0] enabled_r, enabled_nxt;
  logic [NUM_SLOTS-1:0] looping_r, looping_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  result_t              pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_r, out_nxt;

  logic             in_acc;
  logic             cmd_ok;
  logic [IDX_W-1:0] cmd_idx;
  logic             out_free;
  logic             stall;
  logic             scan_done;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  wmask_t           mem_wmask;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;
  expiry_t          exp_res;

  ptsb_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_mask (mem_wmask),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  ptsb_expiry u_expiry (
    .entry   (mem_rdata),
    .now     (now_r),
    .live    (valid_r[eval_idx_r] && enabled_r[eval_idx_r]),
    .looping (looping_r[eval_idx_r]),
    .result  (exp_res)
  );

  // handshake terms
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cmd_ok      = int'(in_ch.slot) < NUM_SLOTS;
  assign cmd_idx     = IDX_W'(in_ch.slot);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign stall       = exp_res.fire && pend_valid_r && !out_free;
  assign scan_done   = (eval_idx_r == LAST_IDX) ||
                       (exp_res.fire && (fire_cnt_r == LAST_FIRE));

  // operation decode and scan sequencer
  always_comb begin
    state_nxt      = state_r;
    eval_idx_nxt   = eval_idx_r;
    now_nxt        = now_r;
    fire_cnt_nxt   = fire_cnt_r;
    valid_nxt      = valid_r;
    enabled_nxt    = enabled_r;
    looping_nxt    = looping_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_waddr      = eval_idx_r;
    mem_wmask      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = eval_idx_r + 1'b1;

    // output beat taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.opcode == OP_SCAN) begin
            now_nxt      = in_ch.time_now;
            eval_idx_nxt = '0;
            fire_cnt_nxt = '0;
            mem_re       = 1'b1;
            mem_raddr    = '0;
            state_nxt    = ST_SCAN;
          end else if (cmd_ok) begin
            mem_waddr = cmd_idx;
            unique case (in_ch.opcode)
              OP_CREATE: begin
                valid_nxt[cmd_idx]   = 1'b1;
                enabled_nxt[cmd_idx] = 1'b0;
                looping_nxt[cmd_idx] = 1'b0;
                mem_we               = 1'b1;
                mem_wmask            = '{remaining: 1'b1, period: 1'b1, start: 1'b1};
                mem_wdata            = '{remaining: '0, period: in_ch.period_value,
                                         start: in_ch.time_now};
              end
              OP_SET_PER: begin
                mem_we    = 1'b1;
                mem_wmask = '{remaining: 1'b0, period: 1'b1, start: 1'b0};
                mem_wdata = '{remaining: '0, period: in_ch.period_value, start: '0};
              end
              OP_START: begin
                enabled_nxt[cmd_idx] = 1'b1;
                looping_nxt[cmd_idx] = (in_ch.cycle_count == '0);
                mem_we               = 1'b1;
                mem_wmask            = '{remaining: 1'b1, period: 1'b0, start: 1'b1};
                mem_wdata            = '{remaining: in_ch.cycle_count, period: '0,
                                         start: in_ch.time_now};
              end
              OP_STOP: begin
                enabled_nxt[cmd_idx] = 1'b0;
                mem_we               = 1'b1;
                mem_wmask            = '{remaining: 1'b1, period: 1'b0, start: 1'b1};
                mem_wdata            = '{remaining: '0, period: '0, start: in_ch.time_now};
              end
              OP_RELEASE: begin
                valid_nxt[cmd_idx]   = 1'b0;
                enabled_nxt[cmd_idx] = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          // expiring slot: write back, hand the held beat on, hold the new one
          if (exp_res.fire) begin
            mem_we                  = 1'b1;
            mem_wmask               = '{remaining: 1'b1, period: 1'b0, start: 1'b1};
            mem_wdata               = '{remaining: exp_res.remaining, period: '0,
                                        start: now_r};
            enabled_nxt[eval_idx_r] = exp_res.enabled;
            if (pend_valid_r) begin
              out_valid_nxt     = 1'b1;
              out_nxt           = pend_r;
              out_nxt.last_fire = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_nxt       = '{fired_slot: SLOT_W'(eval_idx_r),
                               remaining_count: exp_res.remaining,
                               still_enabled: exp_res.enabled, last_fire: 1'b0};
            fire_cnt_nxt   = fire_cnt_r + 1'b1;
          end
          // next slot or wind up
          if (scan_done) begin
            state_nxt = ST_FLUSH;
          end else begin
            eval_idx_nxt = eval_idx_r + 1'b1;
            mem_re       = 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt           = pend_r;
          out_nxt.last_fire = 1'b1;
          pend_valid_nxt    = 1'b0;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      eval_idx_r   <= '0;
      fire_cnt_r   <= '0;
      valid_r      <= '0;
      enabled_r    <= '0;
      looping_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      eval_idx_r   <= eval_idx_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      valid_r      <= valid_nxt;
      enabled_r    <= enabled_nxt;
      looping_r    <= looping_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    now_r  <= now_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // output channel
  assign out_ch.valid           = out_valid_r;
  assign out_ch.fired_slot      = out_r.fired_slot;
  assign out_ch.remaining_count = out_r.remaining_count;
  assign out_ch.still_enabled   = out_r.still_enabled;
  assign out_ch.last_fire       = out_r.last_fire;

  // checks
  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= MAX_FIRES)
    else $error("fire count above limit");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("slot memory read and write hit the same entry");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("held fire beat left behind after scan");

  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.opcode == OP_SCAN)) |=> (state_r == ST_SCAN) && (eval_idx_r == '0))
    else $error("scan did not start at slot zero");

endmodule
